// ===== sv/rcr_pkg.sv =====
// Shared types, codes and framing constants for the capture record ring.
package rcr_pkg;

    // Operation codes of a request transaction
    localparam logic [2:0] OP_HEADER  = 3'd0;
    localparam logic [2:0] OP_PAYLOAD = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_CLAIM   = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;

    // Owner codes
    localparam logic [1:0] OWNER_VACANT  = 2'd0;
    localparam logic [1:0] OWNER_NET     = 2'd1;
    localparam logic [1:0] OWNER_BROWSER = 2'd2;

    // Command kinds handed from the front end to the back end
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_HDR  = 2'd1;
    localparam logic [1:0] CMD_PUT  = 2'd2;
    localparam logic [1:0] CMD_GET  = 2'd3;

    // Record framing
    localparam logic [7:0] FRAME_MARK  = 8'hEC;
    localparam int         FRAME_BYTES = 10;
    localparam int         FRAME_CNT_W = 4;
    localparam int         LEN_W       = 16;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  direction;
        logic [7:0]  endpoint;
        logic [15:0] payload_length;
        logic [31:0] timestamp_ms;
        logic [7:0]  data_byte;
        logic [1:0]  owner_id;
    } rcr_req_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        record_accepted;
        logic        record_dropped;
        logic        claim_ok;
        logic [31:0] drop_total;
        logic [1:0]  current_owner;
        logic [13:0] free_space;
    } rcr_rsp_t;

    // One queued command; the ring address travels beside it
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  direction;
        logic [7:0]  endpoint;
        logic [15:0] payload_length;
        logic [31:0] timestamp_ms;
        logic [7:0]  data_byte;
        rcr_rsp_t    res;
    } rcr_cmd_t;

    // Framing byte number idx of a header record
    function automatic logic [7:0] frame_byte(input logic [FRAME_CNT_W-1:0] idx,
                                              input rcr_cmd_t cmd);
        logic [7:0] b;
        b = 8'd0;
        unique case (idx)
            4'd0:    b = FRAME_MARK;
            4'd1:    b = cmd.direction;
            4'd2:    b = cmd.endpoint;
            4'd3:    b = 8'd0;
            4'd4:    b = cmd.timestamp_ms[7:0];
            4'd5:    b = cmd.timestamp_ms[15:8];
            4'd6:    b = cmd.timestamp_ms[23:16];
            4'd7:    b = cmd.timestamp_ms[31:24];
            4'd8:    b = cmd.payload_length[7:0];
            4'd9:    b = cmd.payload_length[15:8];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/rcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/rcr_queue.sv =====
// Short command FIFO between the front end and the back end.
module rcr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);

endmodule

// ===== sv/rcr_front.sv =====
// Front end: accepts transactions, tracks ring state and issues ring commands.
module rcr_front
    import rcr_pkg::*;
#(
    parameter int RING_BYTES = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  rcr_req_t                      req,
    input  logic                          queue_full,
    output logic                          push,
    output rcr_cmd_t                      push_cmd,
    output logic [$clog2(RING_BYTES)-1:0] push_addr
);

    localparam int AW   = $clog2(RING_BYTES);
    localparam int CW   = AW + 1;
    localparam int CMPW = (CW > LEN_W + 1) ? CW : LEN_W + 1;

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [1:0]    owner_reg, owner_next;
    logic [31:0]   drops_reg, drops_next;
    logic [15:0]   left_reg, left_next;

    logic [CW-1:0] free_now;
    logic [CW-1:0] free_after;
    logic [31:0]   free_ext;
    logic [CW-1:0] wp_sum;
    logic [AW-1:0] wp_plus1;
    logic [AW-1:0] wp_plus_frame;
    logic [AW-1:0] rp_plus1;
    logic          room_short;

    // Free bytes for a given pair of positions, one slot always kept empty
    function automatic logic [CW-1:0] ring_free(input logic [AW-1:0] w,
                                                input logic [AW-1:0] r);
        logic [CW-1:0] used;
        if (w >= r)
        begin
            used = CW'(w) - CW'(r);
        end
        else
        begin
            used = CW'(w) + CW'(RING_BYTES) - CW'(r);
        end
        return CW'(RING_BYTES - 1) - used;
    endfunction

    assign push      = req_valid && !queue_full;
    assign req_stall = queue_full;

    // Position arithmetic with wrap at the ring size
    always_comb
    begin
        free_now      = ring_free(wp_reg, rp_reg);
        wp_plus1      = (wp_reg == AW'(RING_BYTES - 1)) ? '0 : wp_reg + 1'b1;
        rp_plus1      = (rp_reg == AW'(RING_BYTES - 1)) ? '0 : rp_reg + 1'b1;
        wp_sum        = CW'(wp_reg) + CW'(FRAME_BYTES);
        wp_plus_frame = (wp_sum >= CW'(RING_BYTES)) ? AW'(wp_sum - CW'(RING_BYTES))
                                                    : AW'(wp_sum);
        room_short    = CMPW'(free_now) < (CMPW'(req.payload_length) + CMPW'(FRAME_BYTES));
    end

    // Transaction decode and state update
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        owner_next = owner_reg;
        drops_next = drops_reg;
        left_next  = left_reg;
        push_cmd   = '0;
        push_addr  = wp_reg;

        push_cmd.kind           = CMD_NONE;
        push_cmd.direction      = req.direction;
        push_cmd.endpoint       = req.endpoint;
        push_cmd.payload_length = req.payload_length;
        push_cmd.timestamp_ms   = req.timestamp_ms;
        push_cmd.data_byte      = req.data_byte;

        unique case (req.op)
            OP_HEADER:
            begin
                left_next = '0;
                if (owner_reg != OWNER_VACANT)
                begin
                    if (room_short)
                    begin
                        drops_next                 = drops_reg + 32'd1;
                        push_cmd.res.record_dropped = 1'b1;
                    end
                    else
                    begin
                        push_cmd.kind                = CMD_HDR;
                        wp_next                      = wp_plus_frame;
                        left_next                    = req.payload_length;
                        push_cmd.res.record_accepted = 1'b1;
                    end
                end
            end
            OP_PAYLOAD:
            begin
                if (left_reg != '0 && free_now != '0)
                begin
                    push_cmd.kind = CMD_PUT;
                    wp_next       = wp_plus1;
                    left_next     = left_reg - 16'd1;
                end
            end
            OP_READ:
            begin
                if (rp_reg != wp_reg)
                begin
                    push_cmd.kind           = CMD_GET;
                    push_addr               = rp_reg;
                    rp_next                 = rp_plus1;
                    push_cmd.res.read_valid = 1'b1;
                end
            end
            OP_CLAIM:
            begin
                if ((req.owner_id == OWNER_NET || req.owner_id == OWNER_BROWSER)
                    && owner_reg == OWNER_VACANT)
                begin
                    owner_next            = req.owner_id;
                    rp_next               = wp_reg;
                    drops_next            = '0;
                    left_next             = '0;
                    push_cmd.res.claim_ok = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (req.owner_id != OWNER_VACANT && owner_reg == req.owner_id)
                begin
                    owner_next = OWNER_VACANT;
                end
            end
            default:
            begin
                // unused op codes leave everything alone
            end
        endcase

        free_after                 = ring_free(wp_next, rp_next);
        free_ext                   = 32'(free_after);
        push_cmd.res.drop_total    = drops_next;
        push_cmd.res.current_owner = owner_next;
        push_cmd.res.free_space    = free_ext[13:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            owner_reg <= OWNER_VACANT;
            drops_reg <= '0;
            left_reg  <= '0;
        end
        else if (push)
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            owner_reg <= owner_next;
            drops_reg <= drops_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== sv/rcr_back.sv =====
// Back end: executes ring writes and reads, owns the ring RAM and the result register.
module rcr_back
    import rcr_pkg::*;
#(
    parameter int RING_BYTES = 16384
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_empty,
    input  rcr_cmd_t                      head_cmd,
    input  logic [$clog2(RING_BYTES)-1:0] head_addr,
    output logic                          pop,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output rcr_rsp_t                      rsp
);

    localparam int AW = $clog2(RING_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HDR  = 2'd1;
    localparam logic [1:0] ST_RDW  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]             state_reg, state_next;
    rcr_cmd_t               cmd_reg, cmd_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [FRAME_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rcr_rsp_t               rsp_reg, rsp_next;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [7:0]             wr_data;
    logic                   rd_en;
    logic [7:0]             rd_data;
    logic                   out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign pop      = (state_reg == ST_IDLE) && !queue_empty;

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = frame_byte(cnt_reg, cmd_reg);
        rd_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    cmd_next = head_cmd;
                    pos_next = head_addr;
                    cnt_next = '0;
                    unique case (head_cmd.kind)
                        CMD_HDR:
                        begin
                            state_next = ST_HDR;
                        end
                        CMD_PUT:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_addr;
                            wr_data    = head_cmd.data_byte;
                            state_next = ST_DONE;
                        end
                        CMD_GET:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_RDW;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_HDR:
            begin
                // one framing byte per cycle
                wr_en    = 1'b1;
                pos_next = (pos_reg == AW'(RING_BYTES - 1)) ? '0 : pos_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == FRAME_CNT_W'(FRAME_BYTES - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDW:
            begin
                cmd_next.res.read_byte = rd_data;
                state_next             = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = cmd_reg.res;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
        rsp_reg <= rsp_next;
    end

    rcr_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_addr),
        .rd_data (rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/capture_record_ring.sv =====
// Top level of the capture record ring: front end, command queue, back end.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------
//  req     | in        | req_valid / req_stall | rcr_req_t
//  rsp     | out       | rsp_valid / rsp_stall | rcr_rsp_t
//
// Every request transaction yields exactly one response transaction.
// Back end: a header that opens a record writes its ten framing bytes through
// the single RAM write port, a read waits for the registered RAM read, and all
// others go on to the result. The front end decides each one combinationally.
// Reset clears positions, owner, drop count and queue; ring contents are
// undefined and never read before written, so there is no clearing pass.
// req_stall rises while the command queue is full; rsp_stall holds the result.
module capture_record_ring
    import rcr_pkg::*;
#(
    parameter int RING_BYTES  = 16384,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  rcr_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output rcr_rsp_t rsp
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int QW = AW + $bits(rcr_cmd_t);

    logic          push;
    rcr_cmd_t      push_cmd;
    logic [AW-1:0] push_addr;
    logic          queue_full;
    logic          queue_empty;
    logic          pop;
    logic [QW-1:0] head_data;
    rcr_cmd_t      head_cmd;
    logic [AW-1:0] head_addr;

    rcr_front #(
        .RING_BYTES (RING_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_addr  (push_addr)
    );

    rcr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_addr, push_cmd}),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head_data),
        .empty     (queue_empty)
    );

    assign head_addr = head_data[QW-1 -: AW];
    assign head_cmd  = head_data[$bits(rcr_cmd_t)-1:0];

    rcr_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .head_addr   (head_addr),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule
